// ----- design/rtvpb_pkg.sv -----
// Package for the raster to vertical page byte converter.
// Holds size constants, register indexes, reset values and the clamp helper.
// No dependencies.
package rtvpb_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;

	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = $clog2(MAX_HEIGHT);
	localparam int DIM_W     = 9;
	localparam int PAGE_W    = 5;
	localparam int LEVEL_W   = 8;
	localparam int STORE_W   = 7;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_TOP_FIRST = 2'd2;

	localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 9'd128;
	localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 9'd64;
	localparam logic             RST_TOP_FIRST    = 1'b0;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] res;
		if (v == '0) begin
			res = DIM_W'(1);
		end else if (v > maxv) begin
			res = maxv;
		end else begin
			res = v;
		end
		return res;
	endfunction

endpackage

// ----- design/rtvpb_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// Read data holds while read enable is low. No dependencies.
module rtvpb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- design/raster_to_vertical_page_bytes.sv -----
// Channel   | Handshake               | Payload
// ----------+-------------------------+-------------------------------------------
// pixel     | pixel_valid/pixel_stall | red_level
// byte      | byte_valid/byte_stall   | page_byte, page_index, column, page_end,
//           |                         | frame_end
// cfg       | cfg_valid/cfg_ready     | cfg_index, cfg_data
//
// One pixel per cycle while pixel_stall is low. The pixel that completes a byte
// is registered in stage 1, the byte then in the output register. The column
// line store read is registered, with forwarding of a write in the same cycle.
// arst_n clears counters, config and valids, not the data or the line store.
// A stalled byte holds the output register; pixel_stall rises only when the
// stage behind the line store is also full.
// Top level: uses rtvpb_pkg and rtvpb_ram.
module raster_to_vertical_page_bytes
	import rtvpb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic                 pixel_valid,
	output logic                 pixel_stall,
	input  logic [LEVEL_W-1:0]   red_level,
	output logic                 byte_valid,
	input  logic                 byte_stall,
	output logic [7:0]           page_byte,
	output logic [PAGE_W-1:0]    page_index,
	output logic [COL_W-1:0]     column,
	output logic                 page_end,
	output logic                 frame_end
);

	logic [DIM_W-1:0] width_q, height_q;
	logic             top_first_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic [DIM_W-1:0] w, h;
	logic [COL_W-1:0] c;
	logic [ROW_W-1:0] s, y;
	logic [2:0]       r;
	logic [5:0]       pages;
	logic             in_page, row_end, last_page, accept, advance;

	logic               valid_s1, bit_s1, top_s1, clr_s1, emit_s1, wr_s1;
	logic               row_end_s1, last_s1, fwd_hit_s1;
	logic [2:0]         sh_s1;
	logic [COL_W-1:0]   col_s1;
	logic [PAGE_W-1:0]  page_s1;
	logic [STORE_W-1:0] fwd_data_s1;

	logic [STORE_W-1:0] ram_rdata, prior, wdata;
	logic [7:0]         byte_d;
	logic               ram_we;

	assign cfg_ready = 1'b1;

	assign w = clamp_dim(width_q, DIM_W'(MAX_WIDTH));
	assign h = clamp_dim(height_q, DIM_W'(MAX_HEIGHT));
	assign c = ({1'b0, col_q} >= w) ? '0 : col_q;
	assign s = ({1'b0, row_q} >= h) ? '0 : row_q;
	assign y = top_first_q ? s : ROW_W'(h - DIM_W'(1) - {1'b0, s});
	assign r = y[2:0];
	assign pages = h[DIM_W-1:3];
	assign in_page = {1'b0, y[ROW_W-1:3]} < pages;
	assign row_end = ({1'b0, c} == (w - DIM_W'(1)));
	assign last_page = top_first_q ? ({1'b0, y[ROW_W-1:3]} == (pages - 6'd1)) : (y == '0);

	assign advance = !(byte_valid && byte_stall);
	assign pixel_stall = valid_s1 && !advance;
	assign accept = pixel_valid && !pixel_stall;
	assign ram_we = valid_s1 && wr_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= RST_IMAGE_WIDTH;
			height_q <= RST_IMAGE_HEIGHT;
			top_first_q <= RST_TOP_FIRST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:    width_q <= cfg_data;
				REG_IMAGE_HEIGHT:   height_q <= cfg_data;
				REG_ROWS_TOP_FIRST: top_first_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (({1'b0, c} + DIM_W'(1)) >= w) begin
				col_q <= '0;
				row_q <= (({1'b0, s} + DIM_W'(1)) >= h) ? '0 : s + ROW_W'(1);
			end else begin
				col_q <= c + COL_W'(1);
			end
		end
	end

	rtvpb_ram #(
		.WIDTH(STORE_W),
		.DEPTH(MAX_WIDTH)
	) u_line_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(col_s1),
		.wdata(wdata),
		.re   (accept),
		.raddr(c),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bit_s1 <= (red_level == '0);
			top_s1 <= top_first_q;
			clr_s1 <= top_first_q ? (r == 3'd0) : (r == 3'd7);
			emit_s1 <= in_page && (top_first_q ? (r == 3'd7) : (r == 3'd0));
			wr_s1 <= in_page && (top_first_q ? (r != 3'd7) : (r != 3'd0));
			sh_s1 <= top_first_q ? (3'd6 - r) : (3'd7 - r);
			col_s1 <= c;
			page_s1 <= y[ROW_W-1:3];
			row_end_s1 <= row_end;
			last_s1 <= last_page;
			fwd_hit_s1 <= ram_we && (col_s1 == c);
			fwd_data_s1 <= wdata;
		end
	end

	always_comb begin
		prior = clr_s1 ? '0 : (fwd_hit_s1 ? fwd_data_s1 : ram_rdata);
		wdata = prior | (STORE_W'(bit_s1) << sh_s1);
		byte_d = top_s1 ? {prior, bit_s1} : {bit_s1, prior};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
		end else if (advance) begin
			byte_valid <= valid_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit_s1) begin
			page_byte <= byte_d;
			page_index <= page_s1;
			column <= col_s1;
			page_end <= row_end_s1;
			frame_end <= row_end_s1 && last_s1;
		end
	end

endmodule

// ----- design/rtvpb_checker.sv -----
// Port-level checks for raster_to_vertical_page_bytes, attached by bind.
// Uses rtvpb_pkg for port widths.
module rtvpb_checker
	import rtvpb_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              pixel_valid,
	input logic              pixel_stall,
	input logic              byte_valid,
	input logic              byte_stall,
	input logic [7:0]        page_byte,
	input logic [PAGE_W-1:0] page_index,
	input logic [COL_W-1:0]  column,
	input logic              page_end,
	input logic              frame_end
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |=> byte_valid && $stable(page_byte)
			&& $stable(page_index) && $stable(column) && $stable(page_end)
			&& $stable(frame_end))
		else $error("stalled byte request changed");

	a_frame_page: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && frame_end |-> page_end)
		else $error("frame end without page end");

	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_valid |-> !pixel_stall)
		else $error("pixel stall while output is empty");

	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(byte_valid) |-> $past(pixel_valid && !pixel_stall, 2))
		else $error("byte request without a pixel two cycles earlier");

endmodule

bind raster_to_vertical_page_bytes rtvpb_checker u_rtvpb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.pixel_valid(pixel_valid),
	.pixel_stall(pixel_stall),
	.byte_valid (byte_valid),
	.byte_stall (byte_stall),
	.page_byte  (page_byte),
	.page_index (page_index),
	.column     (column),
	.page_end   (page_end),
	.frame_end  (frame_end)
);
